// ===== sv/vss_pkg.sv =====
// ----------------------------------------------------------------------------
// vss_pkg: shared types and constants
// Field widths, register indexes and the configuration bundle of the
// volume sharpening stencil.
// ----------------------------------------------------------------------------
`default_nettype none

package vss_pkg;

    localparam int VOX_W  = 16;
    localparam int VAL_W  = 15;
    localparam int IDX_W  = 24;
    localparam int SUM_W  = 20;
    localparam int WGT_W  = 12;
    localparam int GAIN_W = 32;
    localparam int SZ_W   = 9;
    localparam int LH_W   = 18;

    localparam logic [2:0] REG_SIZE_X  = 3'd0;
    localparam logic [2:0] REG_SIZE_Y  = 3'd1;
    localparam logic [2:0] REG_SIZE_Z  = 3'd2;
    localparam logic [2:0] REG_FLOOR   = 3'd3;
    localparam logic [2:0] REG_CEILING = 3'd4;
    localparam logic [2:0] REG_WEIGHT  = 3'd5;
    localparam logic [2:0] REG_GAIN    = 3'd6;

    typedef struct packed {
        logic [SZ_W-1:0]   size_x;
        logic [SZ_W-1:0]   size_y;
        logic [SZ_W-1:0]   size_z;
        logic [VAL_W-1:0]  global_floor;
        logic [VAL_W-1:0]  global_ceiling;
        logic [WGT_W-1:0]  sharpen_weight;
        logic [GAIN_W-1:0] gain;
    } t_cfg;

endpackage

`default_nettype wire

// ===== sv/vss_if.sv =====
// ----------------------------------------------------------------------------
// vss_if: stream channels
// Valid/ready channels for incoming voxels and outgoing sharpened results.
// ----------------------------------------------------------------------------
`default_nettype none

interface vss_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] voxel_value;

    modport source (output valid, output voxel_value, input ready);
    modport sink   (input valid, input voxel_value, output ready);
endinterface

interface vss_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] voxel_index;
    logic [14:0] new_value;

    modport source (output valid, output voxel_index, output new_value, input ready);
    modport sink   (input valid, input voxel_index, input new_value, output ready);
endinterface

`default_nettype wire

// ===== sv/vss_jobq.sv =====
// ----------------------------------------------------------------------------
// vss_jobq: job queue
// Two-entry queue of window jobs between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module vss_jobq #(
    parameter int W = 64
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_data,
    output logic              o_empty
);

    logic [W-1:0] r_buf [2];
    logic         r_wr_ptr;
    logic         r_rd_ptr;
    logic [1:0]   r_cnt;
    logic         full;

    assign o_empty = (r_cnt == 2'd0);
    assign full    = (r_cnt == 2'd2);
    assign o_data  = r_buf[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!full || i_pop))
        else $error("job queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("job queue underflow");

endmodule

`default_nettype wire

// ===== sv/vss_front.sv =====
// ----------------------------------------------------------------------------
// vss_front: voxel front end
// Accepts voxels, tracks the raster position, writes the history memory and,
// given sizes >= 3 and ceiling > floor, queues a job for each interior window.
// ----------------------------------------------------------------------------
`default_nettype none

module vss_front #(
    parameter int MAX_X = 256,
    parameter int MAX_Y = 256,
    parameter int MAX_Z = 256
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire vss_pkg::t_cfg i_cfg,
    vss_in_if.sink             i_vox,
    input  wire logic          i_q_empty,
    input  wire logic          i_back_busy,
    output logic               o_wr_en,
    output logic [$clog2(2*MAX_X*MAX_Y+2*MAX_X+3)-1:0] o_wr_addr,
    output logic [15:0]        o_wr_data,
    output logic               o_push,
    output logic [$clog2(2*MAX_X*MAX_Y+2*MAX_X+3)+$clog2(MAX_X)+$clog2(MAX_Y)
                  +$clog2(MAX_Z)+$clog2(MAX_X+1)+$clog2(MAX_X*MAX_Y+1)-1:0] o_job
);
    import vss_pkg::*;

    localparam int DEPTH = 2*MAX_X*MAX_Y + 2*MAX_X + 3;
    localparam int AW = $clog2(DEPTH);
    localparam int XW = $clog2(MAX_X);
    localparam int YW = $clog2(MAX_Y);
    localparam int ZW = $clog2(MAX_Z);
    localparam int XS = $clog2(MAX_X+1);
    localparam int YS = $clog2(MAX_Y+1);
    localparam int ZS = $clog2(MAX_Z+1);
    localparam int KW = $clog2(MAX_X*MAX_Y+1);

    logic [XS-1:0] sx;
    logic [YS-1:0] sy;
    logic [ZS-1:0] sz;
    logic [KW-1:0] koff_c;
    logic [XW-1:0] r_x, n_x;
    logic [YW-1:0] r_y, n_y;
    logic [ZW-1:0] r_z, n_z;
    logic [AW-1:0] r_wp;
    logic          accept;
    logic          emit;

    always_comb begin
        if (i_cfg.size_x < SZ_W'(3)) begin
            sx = XS'(3);
        end else if (i_cfg.size_x > MAX_X) begin
            sx = XS'(MAX_X);
        end else begin
            sx = XS'(i_cfg.size_x);
        end
        if (i_cfg.size_y < SZ_W'(3)) begin
            sy = YS'(3);
        end else if (i_cfg.size_y > MAX_Y) begin
            sy = YS'(MAX_Y);
        end else begin
            sy = YS'(i_cfg.size_y);
        end
        if (i_cfg.size_z < SZ_W'(3)) begin
            sz = ZS'(3);
        end else if (i_cfg.size_z > MAX_Z) begin
            sz = ZS'(MAX_Z);
        end else begin
            sz = ZS'(i_cfg.size_z);
        end
    end

    assign koff_c = KW'(sx) * KW'(sy);

    // The history memory has one read port, so no voxel enters while a window
    // is still being fetched or waits in the queue.
    assign i_vox.ready = i_q_empty && !i_back_busy;
    assign accept      = i_vox.valid && i_vox.ready;

    assign emit = (i_cfg.size_x >= SZ_W'(3)) && (i_cfg.size_y >= SZ_W'(3))
               && (i_cfg.size_z >= SZ_W'(3))
               && (i_cfg.global_ceiling > i_cfg.global_floor)
               && (r_x >= XW'(2)) && (r_y >= YW'(2)) && (r_z >= ZW'(2))
               && (XS'(r_x) < sx) && (YS'(r_y) < sy) && (ZS'(r_z) < sz);

    always_comb begin
        n_x = r_x;
        n_y = r_y;
        n_z = r_z;
        if (XS'(r_x) + XS'(1) >= sx) begin
            n_x = '0;
            if (YS'(r_y) + YS'(1) >= sy) begin
                n_y = '0;
                n_z = (ZS'(r_z) + ZS'(1) >= sz) ? '0 : r_z + ZW'(1);
            end else begin
                n_y = r_y + YW'(1);
            end
        end else begin
            n_x = r_x + XW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x    <= '0;
            r_y    <= '0;
            r_z    <= '0;
            r_wp   <= '0;
        end else begin
            if (accept) begin
                r_x  <= n_x;
                r_y  <= n_y;
                r_z  <= n_z;
                r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + AW'(1);
            end
        end
    end

    assign o_wr_en   = accept;
    assign o_wr_addr = r_wp;
    assign o_wr_data = i_vox.voxel_value;
    assign o_push    = accept && emit;
    assign o_job     = {r_wp, r_x, r_y, r_z, sx, koff_c};

    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_back_busy || !i_q_empty) |-> !accept)
        else $error("voxel taken while a window fetch is pending");
    a_wp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wp < AW'(DEPTH))
        else $error("history write pointer out of range");

endmodule

`default_nettype wire

// ===== sv/vss_back.sv =====
// ----------------------------------------------------------------------------
// vss_back: window back end
// Holds the voxel history, fetches a job's 27 window voxels, sharpens and
// clamps the centre; if all 27 are positive, an output register presents it.
// ----------------------------------------------------------------------------
`default_nettype none

module vss_back #(
    parameter int MAX_X = 256,
    parameter int MAX_Y = 256,
    parameter int MAX_Z = 256
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire vss_pkg::t_cfg i_cfg,
    input  wire logic          i_wr_en,
    input  wire logic [$clog2(2*MAX_X*MAX_Y+2*MAX_X+3)-1:0] i_wr_addr,
    input  wire logic [15:0]   i_wr_data,
    input  wire logic          i_q_empty,
    input  wire logic [$clog2(2*MAX_X*MAX_Y+2*MAX_X+3)+$clog2(MAX_X)+$clog2(MAX_Y)
                       +$clog2(MAX_Z)+$clog2(MAX_X+1)+$clog2(MAX_X*MAX_Y+1)-1:0] i_job,
    output logic               o_pop,
    output logic               o_busy,
    vss_out_if.source          o_res
);
    import vss_pkg::*;

    localparam int DEPTH = 2*MAX_X*MAX_Y + 2*MAX_X + 3;
    localparam int AW = $clog2(DEPTH);
    localparam int XW = $clog2(MAX_X);
    localparam int YW = $clog2(MAX_Y);
    localparam int ZW = $clog2(MAX_Z);
    localparam int XS = $clog2(MAX_X+1);
    localparam int KW = $clog2(MAX_X*MAX_Y+1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_MULA  = 3'd3;
    localparam logic [2:0] S_MULB  = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [15:0]       r_hist [DEPTH];
    logic [15:0]       r_rd_data;
    logic [AW-1:0]     rd_addr;

    logic [2:0]        r_state;
    logic [AW-1:0]     r_wp;
    logic [XW-1:0]     r_jx;
    logic [YW-1:0]     r_jy;
    logic [ZW-1:0]     r_jz;
    logic [XS-1:0]     r_joff;
    logic [KW-1:0]     r_koff;

    logic [1:0]        r_a, r_b, r_c;
    logic [AW-1:0]     r_boff, r_coff;
    logic [AW-1:0]     tap_dist;
    logic              last_tap;

    logic              r_rd_v, r_rd_corner, r_rd_centre;
    logic              r_ok;
    logic [SUM_W-1:0]  r_sum;
    logic [VAL_W-1:0]  r_mn, r_mx, r_cv;
    logic              pos;

    logic [IDX_W-1:0]  r_idx_a, r_idx_b, r_idx;
    logic [31:0]       ws;
    logic [32:0]       d_c;
    logic [18:0]       lo_raw, hi_raw, fl2, ce2;
    logic signed [32:0] r_d;
    logic              r_dpos;
    logic [LH_W-1:0]   r_lo, r_hi;
    logic [62:0]       r_prod;
    logic [62:0]       lo_sh, hi_sh;
    logic [VAL_W-1:0]  res;
    logic              load;

    logic              r_out_v;
    logic [IDX_W-1:0]  r_out_idx;
    logic [VAL_W-1:0]  r_out_val;

    // History memory: one write port from the front end, one read port here.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_hist[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_hist[rd_addr];
    end

    assign o_pop  = (r_state == S_IDLE) && !i_q_empty;
    assign o_busy = (r_state == S_READ) || (r_state == S_DRAIN);

    // Distance back from the newest voxel; the ring wraps at DEPTH.
    assign tap_dist = AW'(r_a) + r_boff + r_coff;
    assign rd_addr  = (r_wp >= tap_dist) ? (r_wp - tap_dist)
                                         : AW'(r_wp + AW'(DEPTH) - tap_dist);
    assign last_tap = (r_a == 2'd2) && (r_b == 2'd2) && (r_c == 2'd2);

    assign pos = !r_rd_data[15] && (|r_rd_data[14:0]);

    assign ws     = {20'b0, i_cfg.sharpen_weight} * {12'b0, r_sum};
    assign d_c    = {2'b0, r_cv, 16'b0} - {1'b0, ws};
    assign lo_raw = 19'(r_mn) + 19'(r_mn) + 19'(r_mn) - 19'(r_cv);
    assign hi_raw = 19'(r_mx) + 19'(r_mx) + 19'(r_mx) - 19'(r_cv);
    assign fl2    = {3'b0, i_cfg.global_floor, 1'b0};
    assign ce2    = {3'b0, i_cfg.global_ceiling, 1'b0};

    assign lo_sh = {14'b0, r_lo, 31'b0};
    assign hi_sh = {14'b0, r_hi, 31'b0};

    always_comb begin
        if (!r_dpos || (r_prod < lo_sh)) begin
            res = r_lo[VAL_W:1];
        end else if (r_prod > hi_sh) begin
            res = r_hi[VAL_W:1];
        end else begin
            res = r_prod[32+VAL_W-1:32];
        end
    end

    assign load = (r_state == S_OUT) && r_ok && (!r_out_v || o_res.ready);

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            {r_wp, r_jx, r_jy, r_jz, r_joff, r_koff} <= i_job;
        end
        r_rd_corner <= (r_a != 2'd1) && (r_b != 2'd1) && (r_c != 2'd1);
        r_rd_centre <= (r_a == 2'd1) && (r_b == 2'd1) && (r_c == 2'd1);
        if (r_rd_v) begin
            if (r_rd_centre) begin
                r_cv <= r_rd_data[14:0];
            end
            if (!r_rd_corner) begin
                r_sum <= r_sum + SUM_W'(r_rd_data[14:0]);
                if (r_rd_data[14:0] < r_mn) begin
                    r_mn <= r_rd_data[14:0];
                end
                if (r_rd_data[14:0] > r_mx) begin
                    r_mx <= r_rd_data[14:0];
                end
            end
        end else if (o_pop) begin
            r_sum <= '0;
            r_mn  <= '1;
            r_mx  <= '0;
        end
        if (r_state == S_READ) begin
            r_idx_a <= IDX_W'(r_jz - ZW'(1)) * IDX_W'(r_koff);
            r_idx_b <= IDX_W'(r_jy - YW'(1)) * IDX_W'(r_joff) + IDX_W'(r_jx - XW'(1));
        end
        if (r_state == S_MULA) begin
            r_idx  <= r_idx_a + r_idx_b;
            r_d    <= $signed(d_c);
            r_dpos <= !d_c[32] && (|d_c);
            r_lo   <= ($signed(lo_raw) < $signed(fl2)) ? LH_W'(fl2) : LH_W'(lo_raw);
            r_hi   <= (hi_raw > ce2) ? LH_W'(ce2) : LH_W'(hi_raw);
        end
        if (r_state == S_MULB) begin
            r_prod <= {32'b0, r_d[30:0]} * {31'b0, i_cfg.gain};
        end
        if (load) begin
            r_out_idx <= r_idx;
            r_out_val <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_a     <= '0;
            r_b     <= '0;
            r_c     <= '0;
            r_boff  <= '0;
            r_coff  <= '0;
            r_rd_v  <= 1'b0;
            r_ok    <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_rd_v <= (r_state == S_READ);
            if (r_rd_v && !pos) begin
                r_ok <= 1'b0;
            end else if (o_pop) begin
                r_ok <= 1'b1;
            end
            if (load) begin
                r_out_v <= 1'b1;
            end else if (o_res.ready) begin
                r_out_v <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_a     <= '0;
                        r_b     <= '0;
                        r_c     <= '0;
                        r_boff  <= '0;
                        r_coff  <= '0;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    if (r_a == 2'd2) begin
                        r_a <= '0;
                        if (r_b == 2'd2) begin
                            r_b    <= '0;
                            r_boff <= '0;
                            r_c    <= r_c + 2'd1;
                            r_coff <= r_coff + AW'(r_koff);
                        end else begin
                            r_b    <= r_b + 2'd1;
                            r_boff <= r_boff + AW'(r_joff);
                        end
                    end else begin
                        r_a <= r_a + 2'd1;
                    end
                    if (last_tap) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: r_state <= S_MULA;
                S_MULA:  r_state <= S_MULB;
                S_MULB:  r_state <= S_OUT;
                S_OUT: begin
                    if (!r_ok || load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.valid       = r_out_v;
    assign o_res.voxel_index = r_out_idx;
    assign o_res.new_value   = r_out_val;

    a_pop_starts_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == S_READ))
        else $error("job popped without starting a window fetch");
    a_read_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |-> !i_wr_en)
        else $error("history written during a window fetch");

endmodule

`default_nettype wire

// ===== sv/volume_sharpen_stencil_top.sv =====
// ----------------------------------------------------------------------------
// volume_sharpen_stencil_top: 3D sharpening stencil
// 18-neighbour sharpening of interior voxels of a raster-order volume stream.
//
//  Port group  Dir  Handshake          Payload
//  i_vox       in   valid/ready        voxel_value (s16)
//  o_res       out  valid/ready        voxel_index (u24), new_value (u15)
//  APB         in   psel/penable       7 registers at 4*i, 32-bit data
//
// A voxel that completes no interior window is taken while no fetch is pending.
// A voxel that completes a window holds the input while the back end reads
// its 27 window voxels one a cycle through the single history read port.
// The sharpening multiplies and clamp then run in states MULA, MULB and OUT,
// overlapping the next voxels; the result waits in an output register.
// Reset is synchronous; the history memory is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module volume_sharpen_stencil_top #(
    parameter int MAX_X = 256,
    parameter int MAX_Y = 256,
    parameter int MAX_Z = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    vss_in_if.sink           i_vox,
    vss_out_if.source        o_res,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import vss_pkg::*;

    localparam int DEPTH = 2*MAX_X*MAX_Y + 2*MAX_X + 3;
    localparam int AW = $clog2(DEPTH);
    localparam int JW = AW + $clog2(MAX_X) + $clog2(MAX_Y) + $clog2(MAX_Z)
                      + $clog2(MAX_X+1) + $clog2(MAX_X*MAX_Y+1);

    t_cfg          r_cfg;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [15:0]   wr_data;
    logic          push, pop, q_empty, back_busy;
    logic [JW-1:0] job_in, job_out;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.size_x         <= SZ_W'(256);
            r_cfg.size_y         <= SZ_W'(256);
            r_cfg.size_z         <= SZ_W'(256);
            r_cfg.global_floor   <= VAL_W'(1);
            r_cfg.global_ceiling <= VAL_W'(32767);
            r_cfg.sharpen_weight <= WGT_W'(1724);
            r_cfg.gain           <= GAIN_W'(131072);
        end else if (psel && penable && pwrite) begin
            unique case (paddr[4:2])
                REG_SIZE_X:  r_cfg.size_x         <= pwdata[SZ_W-1:0];
                REG_SIZE_Y:  r_cfg.size_y         <= pwdata[SZ_W-1:0];
                REG_SIZE_Z:  r_cfg.size_z         <= pwdata[SZ_W-1:0];
                REG_FLOOR:   r_cfg.global_floor   <= pwdata[VAL_W-1:0];
                REG_CEILING: r_cfg.global_ceiling <= pwdata[VAL_W-1:0];
                REG_WEIGHT:  r_cfg.sharpen_weight <= pwdata[WGT_W-1:0];
                REG_GAIN:    r_cfg.gain           <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_SIZE_X:  prdata = 32'(r_cfg.size_x);
            REG_SIZE_Y:  prdata = 32'(r_cfg.size_y);
            REG_SIZE_Z:  prdata = 32'(r_cfg.size_z);
            REG_FLOOR:   prdata = 32'(r_cfg.global_floor);
            REG_CEILING: prdata = 32'(r_cfg.global_ceiling);
            REG_WEIGHT:  prdata = 32'(r_cfg.sharpen_weight);
            REG_GAIN:    prdata = r_cfg.gain;
            default:     prdata = '0;
        endcase
    end

    vss_front #(.MAX_X(MAX_X), .MAX_Y(MAX_Y), .MAX_Z(MAX_Z)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_vox       (i_vox),
        .i_q_empty   (q_empty),
        .i_back_busy (back_busy),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_push      (push),
        .o_job       (job_in)
    );

    vss_jobq #(.W(JW)) u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (job_in),
        .i_pop   (pop),
        .o_data  (job_out),
        .o_empty (q_empty)
    );

    vss_back #(.MAX_X(MAX_X), .MAX_Y(MAX_Y), .MAX_Z(MAX_Z)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_q_empty (q_empty),
        .i_job     (job_out),
        .o_pop     (pop),
        .o_busy    (back_busy),
        .o_res     (o_res)
    );

endmodule

`default_nettype wire
